>>> design/pst_pkg.sv
// ----------------------------------------------------------------------------
// Process state table package
// Shared constants, codes and the sequencer control store.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int PST_ENTRIES = 32;

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 8;
  localparam int RC_W    = 3;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_KILL    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESUME  = 2'd3;

  // Entry modes
  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_SUSP = 2'd2;

  // Result codes
  localparam logic [RC_W-1:0] RC_OK       = 3'd0;
  localparam logic [RC_W-1:0] RC_FULL     = 3'd1;
  localparam logic [RC_W-1:0] RC_DUP      = 3'd2;
  localparam logic [RC_W-1:0] RC_NOTFOUND = 3'd3;
  localparam logic [RC_W-1:0] RC_ALREADY  = 3'd4;
  localparam logic [RC_W-1:0] RC_NOTSUSP  = 3'd5;
  localparam logic [RC_W-1:0] RC_EMPTY    = 3'd6;
  localparam logic [RC_W-1:0] RC_NONESUSP = 3'd7;

  // Sequencer step addresses
  typedef logic [1:0] step_t;
  localparam step_t STEP_WAIT   = 2'd0;
  localparam step_t STEP_SCAN   = 2'd1;
  localparam step_t STEP_COMMIT = 2'd2;

  typedef enum logic [1:0] {
    COND_IN_FIRE,
    COND_SCAN_DONE,
    COND_OUT_FREE
  } cond_t;

  // One control word: when the condition holds the sequencer moves to
  // next_step and the gated actions fire; otherwise it stays on this step.
  typedef struct packed {
    cond_t cond;
    step_t next_step;
    logic  latch_req;
    logic  scan_step;
    logic  commit;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t cw;
    case (step)
      STEP_WAIT:   cw = '{cond: COND_IN_FIRE,   next_step: STEP_SCAN,
                          latch_req: 1'b1, scan_step: 1'b0, commit: 1'b0};
      STEP_SCAN:   cw = '{cond: COND_SCAN_DONE, next_step: STEP_COMMIT,
                          latch_req: 1'b0, scan_step: 1'b1, commit: 1'b0};
      STEP_COMMIT: cw = '{cond: COND_OUT_FREE,  next_step: STEP_WAIT,
                          latch_req: 1'b0, scan_step: 1'b0, commit: 1'b1};
      default:     cw = '{cond: COND_IN_FIRE,   next_step: STEP_WAIT,
                          latch_req: 1'b0, scan_step: 1'b0, commit: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

>>> design/process_state_table.sv
// ----------------------------------------------------------------------------
// Process state table
// Table of process entries handling create, suspend, kill and resume requests.
// ----------------------------------------------------------------------------
// Requests are handled one at a time: in_ready is high only in the wait step, so a
// new request is taken only after the previous one has committed. The identifier search walks
// the identifier RAM one slot per cycle through its single read port.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) frees every entry and clears both counts.
module process_state_table
  import pst_pkg::*;
#(
  parameter int ENTRIES = PST_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [ID_W-1:0]    in_proc_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RC_W-1:0]    out_result_code,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [COUNT_W-1:0] out_live_total,
  output logic [COUNT_W-1:0] out_suspended_total
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // Sequencer
  step_t step_r, step_nxt;
  ctrl_t cw;
  logic  cond_ok;

  // Request and scan state
  logic [FUNC_W-1:0] req_func_r;
  logic [ID_W-1:0]   req_id_r;
  logic [CW-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     found_idx_r, found_idx_nxt;
  logic              found_susp_r, found_susp_nxt;
  logic              free_found_r, free_found_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;

  // Table state
  logic [1:0]    mode_r [ENTRIES];
  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] susp_r, susp_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [RC_W-1:0]    out_rc_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COUNT_W-1:0] out_live_r;
  logic [COUNT_W-1:0] out_susp_r;

  // Datapath signals
  logic            ram_re;
  logic            ram_we;
  logic [ID_W-1:0] ram_rdata;
  logic [1:0]      cmp_mode;
  logic            id_hit;
  logic            free_hit;
  logic            scan_done;
  logic            out_free;
  logic            do_latch;
  logic            do_commit;
  logic [RC_W-1:0] rc;
  logic [AW-1:0]   touch_idx;
  logic            mode_we;
  logic [AW-1:0]   mode_waddr;
  logic [1:0]      mode_wdata;

  assign cw        = ucode_rom(step_r);
  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = (scan_cnt_r == CW'(ENTRIES)) && cmp_vld_r;

  always_comb begin
    case (cw.cond)
      COND_IN_FIRE:   cond_ok = in_valid;
      COND_SCAN_DONE: cond_ok = scan_done;
      COND_OUT_FREE:  cond_ok = out_free;
      default:        cond_ok = 1'b0;
    endcase
  end

  assign in_ready  = (step_r == STEP_WAIT);
  assign do_latch  = cw.latch_req && cond_ok;
  assign do_commit = cw.commit && cond_ok;
  assign step_nxt  = cond_ok ? cw.next_step : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Identifier store: read one slot per scan cycle, written on a create.
  assign ram_re = cw.scan_step && (scan_cnt_r < CW'(ENTRIES));

  pst_ram #(
    .WIDTH (ID_W),
    .DEPTH (ENTRIES)
  ) u_ident_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (req_id_r),
    .re    (ram_re),
    .raddr (scan_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // The compare stage works on the slot that was read in the cycle before.
  assign cmp_mode = mode_r[cmp_idx_r];
  assign id_hit   = cmp_vld_r && (cmp_mode != MODE_FREE) && (ram_rdata == req_id_r)
                    && !found_r;
  assign free_hit = cmp_vld_r && (cmp_mode == MODE_FREE) && !free_found_r;

  always_comb begin
    scan_cnt_nxt   = scan_cnt_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_susp_nxt = found_susp_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    if (do_latch) begin
      scan_cnt_nxt   = '0;
      found_nxt      = 1'b0;
      free_found_nxt = 1'b0;
    end else if (cw.scan_step) begin
      if (ram_re) begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        cmp_idx_nxt  = scan_cnt_r[AW-1:0];
        cmp_vld_nxt  = 1'b1;
      end
      if (id_hit) begin
        found_nxt      = 1'b1;
        found_idx_nxt  = cmp_idx_r;
        found_susp_nxt = (cmp_mode == MODE_SUSP);
      end
      if (free_hit) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = cmp_idx_r;
      end
    end
  end

  // Decision and table update for the request at commit.
  always_comb begin
    rc         = RC_OK;
    touch_idx  = '0;
    mode_we    = 1'b0;
    mode_waddr = found_idx_r;
    mode_wdata = MODE_FREE;
    ram_we     = 1'b0;
    live_nxt   = live_r;
    susp_nxt   = susp_r;
    if (req_func_r == FUNC_CREATE) begin
      if ((live_r >= CW'(ENTRIES)) || !free_found_r) begin
        rc = RC_FULL;
      end else if (found_r) begin
        rc = RC_DUP;
      end else begin
        touch_idx  = free_idx_r;
        mode_we    = 1'b1;
        mode_waddr = free_idx_r;
        mode_wdata = MODE_RUN;
        ram_we     = do_commit;
        live_nxt   = live_r + CW'(1);
      end
    end else if (live_r == '0) begin
      rc = RC_EMPTY;
    end else if ((req_func_r == FUNC_RESUME) && (susp_r == '0)) begin
      rc = RC_NONESUSP;
    end else if (!found_r) begin
      rc = RC_NOTFOUND;
    end else begin
      case (req_func_r)
        FUNC_SUSPEND: begin
          if (!found_susp_r) begin
            touch_idx  = found_idx_r;
            mode_we    = 1'b1;
            mode_wdata = MODE_SUSP;
            susp_nxt   = susp_r + CW'(1);
          end else begin
            rc = RC_ALREADY;
          end
        end
        FUNC_KILL: begin
          if (!found_susp_r) begin
            touch_idx  = found_idx_r;
            mode_we    = 1'b1;
            mode_wdata = MODE_FREE;
            live_nxt   = live_r - CW'(1);
          end else begin
            rc = RC_ALREADY;
          end
        end
        default: begin
          if (found_susp_r) begin
            touch_idx  = found_idx_r;
            mode_we    = 1'b1;
            mode_wdata = MODE_RUN;
            susp_nxt   = susp_r - CW'(1);
          end else begin
            rc = RC_NOTSUSP;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r   <= 1'b0;
      live_r      <= '0;
      susp_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        mode_r[i] <= MODE_FREE;
      end
    end else begin
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_commit) begin
        live_r <= live_nxt;
        susp_r <= susp_nxt;
        if (mode_we) begin
          mode_r[mode_waddr] <= mode_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_latch) begin
      req_func_r <= in_func;
      req_id_r   <= in_proc_id;
    end
    scan_cnt_r   <= scan_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    found_susp_r <= found_susp_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    if (do_commit) begin
      out_rc_r   <= rc;
      out_slot_r <= SLOT_W'(touch_idx);
      out_live_r <= COUNT_W'(live_nxt);
      out_susp_r <= COUNT_W'(susp_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_code     = out_rc_r;
  assign out_slot            = out_slot_r;
  assign out_live_total      = out_live_r;
  assign out_suspended_total = out_susp_r;

endmodule

>>> design/pst_ram.sv
// ----------------------------------------------------------------------------
// Process state table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
